// File: src/mssc_pkg.sv
// ----------------------------------------------------------------------------
// Motor soft start controller package
// Shared types and constants for the configuration registers and the core.
// ----------------------------------------------------------------------------
package mssc_pkg;

	localparam int CFG_ADDR_W = 5;
	localparam int CFG_DATA_W = 32;
	localparam int HOLD_W = 12;
	localparam int PERIOD_W = 8;

	typedef enum logic [2:0] {
		REG_START_DUTY       = 3'd0,
		REG_MAX_DUTY         = 3'd1,
		REG_RAMP_STEP        = 3'd2,
		REG_TAP_STEP         = 3'd3,
		REG_RAMP_PERIOD      = 3'd4,
		REG_INC_PERIOD       = 3'd5,
		REG_RUN_HOLD_TICKS   = 3'd6,
		REG_SPEED_HOLD_TICKS = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [7:0]        start_duty;
		logic [7:0]        max_duty;
		logic [7:0]        ramp_step;
		logic [7:0]        tap_step;
		logic [7:0]        ramp_period;
		logic [7:0]        inc_period;
		logic [HOLD_W-1:0] run_hold_ticks;
		logic [HOLD_W-1:0] speed_hold_ticks;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		start_duty:       8'd100,
		max_duty:         8'd255,
		ramp_step:        8'd5,
		tap_step:         8'd25,
		ramp_period:      8'd20,
		inc_period:       8'd15,
		run_hold_ticks:   12'd1500,
		speed_hold_ticks: 12'd1000
	};

	typedef struct packed {
		logic start_button;
		logic speed_button;
	} item_t;

endpackage

// File: src/mssc_cfg.sv
// ----------------------------------------------------------------------------
// Motor soft start controller configuration registers
// APB register file holding the eight timing and duty settings.
// ----------------------------------------------------------------------------
module mssc_cfg import mssc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready,
	output cfg_t                  cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (wr_en) begin
			case (idx)
				REG_START_DUTY:       cfg_q.start_duty       <= pwdata[7:0];
				REG_MAX_DUTY:         cfg_q.max_duty         <= pwdata[7:0];
				REG_RAMP_STEP:        cfg_q.ramp_step        <= pwdata[7:0];
				REG_TAP_STEP:         cfg_q.tap_step         <= pwdata[7:0];
				REG_RAMP_PERIOD:      cfg_q.ramp_period      <= pwdata[7:0];
				REG_INC_PERIOD:       cfg_q.inc_period       <= pwdata[7:0];
				REG_RUN_HOLD_TICKS:   cfg_q.run_hold_ticks   <= pwdata[HOLD_W-1:0];
				REG_SPEED_HOLD_TICKS: cfg_q.speed_hold_ticks <= pwdata[HOLD_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (idx)
			REG_START_DUTY:       prdata = CFG_DATA_W'(cfg_q.start_duty);
			REG_MAX_DUTY:         prdata = CFG_DATA_W'(cfg_q.max_duty);
			REG_RAMP_STEP:        prdata = CFG_DATA_W'(cfg_q.ramp_step);
			REG_TAP_STEP:         prdata = CFG_DATA_W'(cfg_q.tap_step);
			REG_RAMP_PERIOD:      prdata = CFG_DATA_W'(cfg_q.ramp_period);
			REG_INC_PERIOD:       prdata = CFG_DATA_W'(cfg_q.inc_period);
			REG_RUN_HOLD_TICKS:   prdata = CFG_DATA_W'(cfg_q.run_hold_ticks);
			REG_SPEED_HOLD_TICKS: prdata = CFG_DATA_W'(cfg_q.speed_hold_ticks);
			default:              prdata = '0;
		endcase
	end

endmodule

// File: src/mssc_core.sv
// ----------------------------------------------------------------------------
// Motor soft start controller core
// Holds the run, direction, duty and timer state and advances it by one tick.
// ----------------------------------------------------------------------------
module mssc_core import mssc_pkg::*; #(
	parameter int DEBOUNCE_TICKS  = 20,
	parameter int DEAD_TIME_TICKS = 100,
	parameter int DUTY_BITS       = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 tick,
	input  item_t                item,
	input  cfg_t                 cfg,
	output logic [DUTY_BITS-1:0] duty,
	output logic                 forward,
	output logic                 bridge_on,
	output logic                 running,
	output logic                 continuous_up
);

	localparam int SW = ((DUTY_BITS > 8) ? DUTY_BITS : 8) + 1;
	localparam logic [SW-1:0] DMASK = SW'((64'd1 << DUTY_BITS) - 64'd1);
	localparam logic [PERIOD_W-1:0] DEB_LIM = PERIOD_W'(DEBOUNCE_TICKS);
	localparam logic [PERIOD_W-1:0] DEAD_LIM = PERIOD_W'(DEAD_TIME_TICKS);
	localparam logic [HOLD_W-1:0] HOLD_MAX = '1;

	logic [PERIOD_W-1:0]  debounce_count_q, ramp_count_q, inc_count_q, dead_count_q;
	logic                 debounce_ready_q;
	logic                 start_pressed_q, start_held_q;
	logic [HOLD_W-1:0]    start_hold_count_q, speed_hold_count_q;
	logic                 speed_pressed_q, speed_held_q;
	logic                 run_flag_q, direction_flag_q, reversing_q;
	logic [DUTY_BITS-1:0] duty_level_q;

	logic [PERIOD_W-1:0]  debounce_count_d, ramp_count_d, inc_count_d, dead_count_d;
	logic                 debounce_ready_d;
	logic                 start_pressed_d, start_held_d;
	logic [HOLD_W-1:0]    start_hold_count_d, speed_hold_count_d;
	logic                 speed_pressed_d, speed_held_d;
	logic                 run_flag_d, direction_flag_d, reversing_d;
	logic [SW-1:0]        dl;
	logic [SW-1:0]        sd, md;
	logic [PERIOD_W-1:0]  ramp_inc, inc_inc, dead_inc;
	logic                 ramp_fire, inc_fire, sb, pb;

	always_comb begin
		sb = item.start_button;
		pb = item.speed_button;
		sd = (SW'(cfg.start_duty) > DMASK) ? DMASK : SW'(cfg.start_duty);
		md = (SW'(cfg.max_duty) > DMASK) ? DMASK : SW'(cfg.max_duty);

		debounce_ready_d   = debounce_ready_q;
		start_pressed_d    = start_pressed_q;
		start_held_d       = start_held_q;
		start_hold_count_d = start_hold_count_q;
		speed_pressed_d    = speed_pressed_q;
		speed_held_d       = speed_held_q;
		speed_hold_count_d = speed_hold_count_q;
		run_flag_d         = run_flag_q;
		direction_flag_d   = direction_flag_q;
		reversing_d        = reversing_q;
		dead_count_d       = dead_count_q;
		dl                 = SW'(duty_level_q);

		if (debounce_count_q >= DEB_LIM) begin
			debounce_count_d = '0;
			debounce_ready_d = 1'b1;
		end else begin
			debounce_count_d = debounce_count_q + 1'b1;
		end

		ramp_inc  = ramp_count_q + 1'b1;
		ramp_fire = (ramp_inc >= cfg.ramp_period);
		ramp_count_d = ramp_fire ? '0 : ramp_inc;
		inc_inc   = inc_count_q + 1'b1;
		inc_fire  = (inc_inc >= cfg.inc_period);
		inc_count_d = inc_fire ? '0 : inc_inc;

		if (start_pressed_d) begin
			if (start_hold_count_d != HOLD_MAX) begin
				start_hold_count_d = start_hold_count_d + 1'b1;
			end
			if (start_hold_count_d >= cfg.run_hold_ticks) begin
				start_held_d = 1'b1;
			end
		end
		if (sb && !start_pressed_d && debounce_ready_d) begin
			start_pressed_d    = 1'b1;
			start_hold_count_d = '0;
			debounce_ready_d   = 1'b0;
		end else if (!sb && start_pressed_d && debounce_ready_d) begin
			if (!start_held_d) begin
				run_flag_d = !run_flag_d;
			end else if (run_flag_d && !reversing_d) begin
				reversing_d  = 1'b1;
				dead_count_d = '0;
			end
			start_pressed_d    = 1'b0;
			start_held_d       = 1'b0;
			start_hold_count_d = '0;
			debounce_ready_d   = 1'b0;
		end

		if (reversing_d) begin
			dead_inc = dead_count_d + 1'b1;
			if (dead_inc >= DEAD_LIM) begin
				dead_count_d     = '0;
				direction_flag_d = !direction_flag_d;
				reversing_d      = 1'b0;
			end else begin
				dead_count_d = dead_inc;
			end
		end else begin
			dead_inc = dead_count_d;
		end

		if (ramp_fire) begin
			if (run_flag_d) begin
				if (dl < sd) begin
					dl = dl + SW'(cfg.ramp_step);
					if (dl > sd) begin
						dl = sd;
					end
				end
			end else if (dl != '0) begin
				dl = dl - 1'b1;
			end
		end

		if (speed_pressed_d) begin
			if (speed_hold_count_d != HOLD_MAX) begin
				speed_hold_count_d = speed_hold_count_d + 1'b1;
			end
			if (speed_hold_count_d >= cfg.speed_hold_ticks) begin
				speed_held_d = 1'b1;
			end
		end
		if (pb && !speed_pressed_d && run_flag_d) begin
			speed_pressed_d    = 1'b1;
			speed_hold_count_d = '0;
			debounce_ready_d   = 1'b0;
		end else if (pb && speed_held_d) begin
			if (inc_fire && run_flag_d && dl != '0 && dl < md) begin
				dl = dl + 1'b1;
			end
		end else if (!pb && speed_pressed_d && debounce_ready_d) begin
			if (!speed_held_d && run_flag_d && dl != '0) begin
				dl = dl + SW'(cfg.tap_step);
				if (dl > md) begin
					dl = sd;
				end
			end
			speed_pressed_d    = 1'b0;
			speed_held_d       = 1'b0;
			speed_hold_count_d = '0;
			debounce_ready_d   = 1'b0;
		end

		duty          = reversing_d ? '0 : dl[DUTY_BITS-1:0];
		forward       = direction_flag_d;
		bridge_on     = !reversing_d;
		running       = run_flag_d;
		continuous_up = speed_held_d && pb;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_count_q   <= '0;
			debounce_ready_q   <= 1'b0;
			ramp_count_q       <= '0;
			inc_count_q        <= '0;
			dead_count_q       <= '0;
			start_pressed_q    <= 1'b0;
			start_hold_count_q <= '0;
			start_held_q       <= 1'b0;
			speed_pressed_q    <= 1'b0;
			speed_hold_count_q <= '0;
			speed_held_q       <= 1'b0;
			run_flag_q         <= 1'b0;
			direction_flag_q   <= 1'b1;
			reversing_q        <= 1'b0;
			duty_level_q       <= '0;
		end else if (tick) begin
			debounce_count_q   <= debounce_count_d;
			debounce_ready_q   <= debounce_ready_d;
			ramp_count_q       <= ramp_count_d;
			inc_count_q        <= inc_count_d;
			dead_count_q       <= dead_count_d;
			start_pressed_q    <= start_pressed_d;
			start_hold_count_q <= start_hold_count_d;
			start_held_q       <= start_held_d;
			speed_pressed_q    <= speed_pressed_d;
			speed_hold_count_q <= speed_hold_count_d;
			speed_held_q       <= speed_held_d;
			run_flag_q         <= run_flag_d;
			direction_flag_q   <= direction_flag_d;
			reversing_q        <= reversing_d;
			duty_level_q       <= dl[DUTY_BITS-1:0];
		end
	end

endmodule

// File: src/motor_soft_start_controller.sv
// ----------------------------------------------------------------------------
// Motor soft start controller
// Each tick updates start/stop, reversal dead time, soft ramp and speed
// button logic, and reports duty, direction, bridge enable and mode flags.
// An accepted tick beat is held in the input register, and its result in the
// output register. One tick beat is accepted per cycle while the result side
// is not stalled; the single-pass update sets the rate. A stalled result holds
// in the output register; the input register then accepts a beat only if empty.
// Reset clears all timers and flags, selects forward and loads default registers.
// ----------------------------------------------------------------------------
module motor_soft_start_controller import mssc_pkg::*; #(
	parameter int DEBOUNCE_TICKS  = 20,
	parameter int DEAD_TIME_TICKS = 100,
	parameter int DUTY_BITS       = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// [0] start_button, [1] speed_button
	input  logic [7:0]            s_tdata,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// duty, forward, bridge_on, running, continuous_up from the lowest bit up
	output logic [((DUTY_BITS+4+7)/8)*8-1:0] m_tdata,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready
);

	localparam int OUT_W = ((DUTY_BITS + 4 + 7) / 8) * 8;

	cfg_t                 cfg;
	item_t                item_s1;
	logic                 valid_s1;
	logic                 advance;
	logic [DUTY_BITS-1:0] duty;
	logic                 forward, bridge_on, running, continuous_up;
	logic [OUT_W-1:0]     tdata_s2;
	logic                 valid_s2;

	mssc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	mssc_core #(
		.DEBOUNCE_TICKS  (DEBOUNCE_TICKS),
		.DEAD_TIME_TICKS (DEAD_TIME_TICKS),
		.DUTY_BITS       (DUTY_BITS)
	) u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.tick          (advance),
		.item          (item_s1),
		.cfg           (cfg),
		.duty          (duty),
		.forward       (forward),
		.bridge_on     (bridge_on),
		.running       (running),
		.continuous_up (continuous_up)
	);

	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign m_tvalid = valid_s2;
	assign m_tdata  = tdata_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.start_button <= s_tdata[0];
			item_s1.speed_button <= s_tdata[1];
		end
		if (advance) begin
			tdata_s2 <= OUT_W'({continuous_up, running, bridge_on, forward, duty});
		end
	end

endmodule

// File: src/mssc_checker.sv
// ----------------------------------------------------------------------------
// Motor soft start controller checker
// Port-level assertions on the result stream and the register port.
// ----------------------------------------------------------------------------
module mssc_checker import mssc_pkg::*; #(
	parameter int DUTY_BITS = 8
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tvalid,
	input logic                  s_tready,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [((DUTY_BITS+4+7)/8)*8-1:0] m_tdata,
	input logic                  pready
);

	// The bridge is off only during the dead time, when duty must be zero.
	a_dead_duty: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tdata[DUTY_BITS+1]) |-> (m_tdata[DUTY_BITS-1:0] == '0))
		else $error("duty nonzero while bridge is off");

	// The register port never inserts wait states.
	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> m_tvalid)
		else $error("result beat dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> $stable(m_tdata))
		else $error("result beat changed while stalled");

	// The input side stalls only behind a stalled result.
	a_input_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && !s_tready) |-> (m_tvalid && !m_tready))
		else $error("input stalled while the result side is free");

endmodule

bind motor_soft_start_controller mssc_checker #(.DUTY_BITS(DUTY_BITS)) u_mssc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.pready   (pready)
);
